[sv/keyboard_scancode_to_ascii_macros.svh]
// Assertion macros shared by the checkers of the keyboard scan code translator.
// The macros expect a signal named clk, and the two implication macros also arst_n, in the scope where they are used.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_MACROS_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyboard translator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyboard translator check failed");

// Property checked at every edge, including those during reset.
`define KSA_ASSERT_ANY(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("keyboard translator check failed");

`endif

[sv/ksa_pkg.sv]
package ksa_pkg;

	localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] CAPS_MAKE    = 8'h3A;
	localparam int unsigned RELEASE_BIT = 7;

	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;

	typedef logic [6:0] ascii_t;

	typedef struct packed {
		logic shift;
		logic caps;
	} ksa_flags_t;

	typedef struct packed {
		logic   char_valid;
		ascii_t ascii_char;
		logic   caps_on;
		logic   caps_toggled;
	} ksa_result_t;

	// Unshifted character for codes 0x00..0x3F; zero means no character.
	function automatic ascii_t plain_char(input logic [5:0] idx);
		ascii_t c;
		case (idx)
			6'h02: c = 7'h31;
			6'h03: c = 7'h32;
			6'h04: c = 7'h33;
			6'h05: c = 7'h34;
			6'h06: c = 7'h35;
			6'h07: c = 7'h36;
			6'h08: c = 7'h37;
			6'h09: c = 7'h38;
			6'h0A: c = 7'h39;
			6'h0B: c = 7'h30;
			6'h0C: c = 7'h2D;
			6'h0D: c = 7'h3D;
			6'h0E: c = 7'h08;
			6'h10: c = 7'h71;
			6'h11: c = 7'h77;
			6'h12: c = 7'h65;
			6'h13: c = 7'h72;
			6'h14: c = 7'h74;
			6'h15: c = 7'h79;
			6'h16: c = 7'h75;
			6'h17: c = 7'h69;
			6'h18: c = 7'h6F;
			6'h19: c = 7'h70;
			6'h1A: c = 7'h5B;
			6'h1B: c = 7'h5D;
			6'h1C: c = 7'h0A;
			6'h1E: c = 7'h61;
			6'h1F: c = 7'h73;
			6'h20: c = 7'h64;
			6'h21: c = 7'h66;
			6'h22: c = 7'h67;
			6'h23: c = 7'h68;
			6'h24: c = 7'h6A;
			6'h25: c = 7'h6B;
			6'h26: c = 7'h6C;
			6'h27: c = 7'h3B;
			6'h28: c = 7'h27;
			6'h29: c = 7'h60;
			6'h2B: c = 7'h5C;
			6'h2C: c = 7'h7A;
			6'h2D: c = 7'h78;
			6'h2E: c = 7'h63;
			6'h2F: c = 7'h76;
			6'h30: c = 7'h62;
			6'h31: c = 7'h6E;
			6'h32: c = 7'h6D;
			6'h33: c = 7'h2C;
			6'h34: c = 7'h2E;
			6'h35: c = 7'h2F;
			6'h37: c = 7'h2A;
			6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Shifted character for codes 0x00..0x3F; zero means no character.
	function automatic ascii_t upper_char(input logic [5:0] idx);
		ascii_t c;
		case (idx)
			6'h02: c = 7'h21;
			6'h03: c = 7'h40;
			6'h04: c = 7'h23;
			6'h05: c = 7'h24;
			6'h06: c = 7'h25;
			6'h07: c = 7'h5E;
			6'h08: c = 7'h26;
			6'h09: c = 7'h2A;
			6'h0A: c = 7'h28;
			6'h0B: c = 7'h29;
			6'h0C: c = 7'h5F;
			6'h0D: c = 7'h2B;
			6'h0E: c = 7'h08;
			6'h10: c = 7'h51;
			6'h11: c = 7'h57;
			6'h12: c = 7'h45;
			6'h13: c = 7'h52;
			6'h14: c = 7'h54;
			6'h15: c = 7'h59;
			6'h16: c = 7'h55;
			6'h17: c = 7'h49;
			6'h18: c = 7'h4F;
			6'h19: c = 7'h50;
			6'h1A: c = 7'h7B;
			6'h1B: c = 7'h7D;
			6'h1C: c = 7'h0A;
			6'h1E: c = 7'h41;
			6'h1F: c = 7'h53;
			6'h20: c = 7'h44;
			6'h21: c = 7'h46;
			6'h22: c = 7'h47;
			6'h23: c = 7'h48;
			6'h24: c = 7'h4A;
			6'h25: c = 7'h4B;
			6'h26: c = 7'h4C;
			6'h27: c = 7'h3A;
			6'h28: c = 7'h22;
			6'h29: c = 7'h7E;
			6'h2B: c = 7'h7C;
			6'h2C: c = 7'h5A;
			6'h2D: c = 7'h58;
			6'h2E: c = 7'h43;
			6'h2F: c = 7'h56;
			6'h30: c = 7'h42;
			6'h31: c = 7'h4E;
			6'h32: c = 7'h4D;
			6'h33: c = 7'h3C;
			6'h34: c = 7'h3E;
			6'h35: c = 7'h3F;
			6'h37: c = 7'h2A;
			6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

[sv/ksa_in_if.sv]
interface ksa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_code;

	modport source (output valid, output scan_code, input ready);
	modport sink (input valid, input scan_code, output ready);
endinterface

[sv/ksa_out_if.sv]
interface ksa_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [6:0] ascii_char;
	logic       caps_on;
	logic       caps_toggled;

	modport source (output valid, output char_valid, output ascii_char, output caps_on,
		output caps_toggled, input ready);
	modport sink (input valid, input char_valid, input ascii_char, input caps_on,
		input caps_toggled, output ready);
endinterface

[sv/ksa_lookup.sv]
module ksa_lookup (
	input  logic [7:0]          code,
	input  ksa_pkg::ksa_flags_t flags,
	output ksa_pkg::ascii_t     ch
);
	import ksa_pkg::*;

	ascii_t lo;
	ascii_t hi;
	logic   in_table;
	logic   letter;

	assign in_table = (code[7:6] == 2'b00);
	assign lo       = plain_char(code[5:0]);
	assign hi       = upper_char(code[5:0]);
	// The base table holds only lower-case letters, so one range check suffices.
	assign letter   = (lo >= ASCII_LOWER_A) && (lo <= ASCII_LOWER_Z);

	always_comb begin
		if (!in_table || lo == '0) begin
			ch = '0;
		end else if (letter) begin
			ch = (flags.shift != flags.caps) ? hi : lo;
		end else if (flags.shift) begin
			ch = (hi != '0) ? hi : lo;
		end else begin
			ch = lo;
		end
	end
endmodule

[sv/ksa_decode.sv]
module ksa_decode (
	input  logic [7:0]           code,
	input  ksa_pkg::ksa_flags_t  flags_cur,
	output ksa_pkg::ksa_flags_t  flags_nxt,
	output ksa_pkg::ksa_result_t res
);
	import ksa_pkg::*;

	ascii_t lookup_ch;
	logic   is_shift_make;
	logic   is_shift_break;
	logic   is_caps_make;
	logic   is_release;

	ksa_lookup u_lookup (
		.code  (code),
		.flags (flags_cur),
		.ch    (lookup_ch)
	);

	assign is_shift_make  = (code == LSHIFT_MAKE) || (code == RSHIFT_MAKE);
	assign is_shift_break = (code == LSHIFT_BREAK) || (code == RSHIFT_BREAK);
	assign is_caps_make   = (code == CAPS_MAKE);
	assign is_release     = code[RELEASE_BIT];

	always_comb begin
		flags_nxt        = flags_cur;
		res.ascii_char   = '0;
		res.caps_toggled = 1'b0;
		if (is_shift_make) begin
			flags_nxt.shift = 1'b1;
		end else if (is_shift_break) begin
			flags_nxt.shift = 1'b0;
		end else if (is_caps_make) begin
			flags_nxt.caps   = !flags_cur.caps;
			res.caps_toggled = 1'b1;
		end else if (!is_release) begin
			res.ascii_char = lookup_ch;
		end
		res.char_valid = (res.ascii_char != '0);
		res.caps_on    = flags_nxt.caps;
	end
endmodule

[sv/keyboard_scancode_to_ascii.sv]
// Translates PC keyboard scan codes (set 1) into ASCII, one scan code byte per
// item on the scan channel and exactly one result item per scan code on the
// result channel. The block tracks two flags: shift held (set by the left or
// right shift make codes and cleared by their break codes) and caps lock
// (flipped by each caps lock make code). Every result carries char_valid and
// ascii_char (zero when no character was produced), the caps lock state after
// the code, and caps_toggled. The block accepts one item per clock cycle unless
// back-pressure stalls it; a scan code is captured in an input register,
// translated combinationally by table lookup, and the result is then
// captured in the output register. The output register and input register
// stall together under back-pressure, and the flags update only when a
// translated item moves into the output register, so results always follow
// the order of the scan codes.
module keyboard_scancode_to_ascii (
	input logic         clk,
	input logic         arst_n,
	ksa_in_if.sink      scan,
	ksa_out_if.source   result
);
	import ksa_pkg::*;

	// Input stage.
	logic        valid_s1;
	logic [7:0]  code_s1;

	// Output stage.
	logic        valid_s2;
	ksa_result_t result_s2;

	// Keyboard flags as seen after the last translated item.
	ksa_flags_t  flags_q;

	ksa_flags_t  flags_nxt;
	ksa_result_t res_nxt;
	logic        advance;

	// The input stage moves forward whenever the output register is free or
	// is being emptied in this cycle.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign scan.ready = !valid_s1 || advance;

	ksa_decode u_decode (
		.code      (code_s1),
		.flags_cur (flags_q),
		.flags_nxt (flags_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			code_s1 <= scan.scan_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			flags_q  <= flags_nxt;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_nxt;
		end
	end

	assign result.valid        = valid_s2;
	assign result.char_valid   = result_s2.char_valid;
	assign result.ascii_char   = result_s2.ascii_char;
	assign result.caps_on      = result_s2.caps_on;
	assign result.caps_toggled = result_s2.caps_toggled;
endmodule

[sv/ksa_checker.sv]
`include "keyboard_scancode_to_ascii_macros.svh"

module ksa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       char_valid,
	input logic [6:0] ascii_char,
	input logic       caps_on,
	input logic       caps_toggled
);
	// A character is reported exactly when the code is nonzero.
	`KSA_ASSERT_IMP(a_char_flag, out_valid, char_valid == (ascii_char != 7'h00))
	// A caps lock toggle never produces a character.
	`KSA_ASSERT_IMP(a_toggle_no_char, out_valid && caps_toggled, !char_valid)
	// No result is presented on the first edge after reset is released.
	`KSA_ASSERT_ANY(a_reset_empty, $rose(arst_n) |-> !out_valid)
	// A stalled result holds until taken.
	`KSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(char_valid) && $stable(ascii_char) && $stable(caps_on)
		&& $stable(caps_toggled))
endmodule

bind keyboard_scancode_to_ascii ksa_checker u_ksa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.char_valid   (result.char_valid),
	.ascii_char   (result.ascii_char),
	.caps_on      (result.caps_on),
	.caps_toggled (result.caps_toggled)
);

[test/scancode_checker.sv]
`timescale 1ns / 100ps

module scancode_checker (
	input  logic clk,
	input  logic arst_n,
	ksa_in_if    scan,
	ksa_out_if   result,
	output int   mismatches,
	output int   pending,
	output int   chars_seen,
	output int   toggles_seen
);
	import ksa_pkg::*;

	typedef struct packed {
		logic [7:0] base;
		logic [7:0] shifted;
	} key_pair_t;

	logic        shift_held;
	logic        caps_active;
	ksa_result_t predicted_results[$];
	ksa_result_t oldest;
	int          mismatch_count = 0;
	int          pending_count = 0;
	int          char_count = 0;
	int          toggle_count = 0;

	assign mismatches   = mismatch_count;
	assign pending      = pending_count;
	assign chars_seen   = char_count;
	assign toggles_seen = toggle_count;

	// Both characters of a key in the lowest quarter of the code space; zero marks no character.
	function automatic key_pair_t key_chars(input logic [5:0] k);
		string     lo_row;
		string     hi_row;
		int        first;
		key_pair_t kp;
		kp = '0;
		first = -1;
		if (k >= 6'h02 && k <= 6'h0D) begin
			lo_row = "1234567890-=";
			hi_row = "!@#$%^&*()_+";
			first = 'h02;
		end else if (k >= 6'h10 && k <= 6'h1B) begin
			lo_row = "qwertyuiop[]";
			hi_row = "QWERTYUIOP{}";
			first = 'h10;
		end else if (k >= 6'h1E && k <= 6'h28) begin
			lo_row = "asdfghjkl;'";
			hi_row = "ASDFGHJKL:\"";
			first = 'h1E;
		end else if (k >= 6'h2B && k <= 6'h35) begin
			lo_row = "\\zxcvbnm,./";
			hi_row = "|ZXCVBNM<>?";
			first = 'h2B;
		end
		if (first >= 0) begin
			kp.base    = lo_row[k - first];
			kp.shifted = hi_row[k - first];
		end else begin
			case (k)
				6'h0E: kp = {8'h08, 8'h08};  // backspace
				6'h1C: kp = {8'h0A, 8'h0A};  // enter
				6'h29: kp = {8'h60, 8'h7E};  // grave accent and tilde
				6'h37: kp = {8'h2A, 8'h2A};  // keypad star
				6'h39: kp = {8'h20, 8'h20};  // space bar
				default: kp = '0;
			endcase
		end
		return kp;
	endfunction

	// Updates the shift and caps lock flags and returns the result one scan code gives.
	function automatic ksa_result_t predict_key(input logic [7:0] code);
		ksa_result_t r;
		key_pair_t   kp;
		logic [7:0]  ch;
		ch = '0;
		r = '0;
		if (code == LSHIFT_MAKE || code == RSHIFT_MAKE) begin
			shift_held = 1'b1;
		end else if (code == LSHIFT_BREAK || code == RSHIFT_BREAK) begin
			shift_held = 1'b0;
		end else if (code == CAPS_MAKE) begin
			caps_active = ~caps_active;
			r.caps_toggled = 1'b1;
		end else if (!code[RELEASE_BIT] && !code[6]) begin
			kp = key_chars(code[5:0]);
			if (kp.base == 8'h00) begin
				ch = '0;
			end else if (kp.base >= ASCII_LOWER_A && kp.base <= ASCII_LOWER_Z) begin
				ch = (shift_held != caps_active) ? kp.shifted : kp.base;
			end else if (shift_held) begin
				ch = (kp.shifted != 8'h00) ? kp.shifted : kp.base;
			end else begin
				ch = kp.base;
			end
		end
		r.char_valid = (ch != 8'h00);
		r.ascii_char = ch[6:0];
		r.caps_on    = caps_active;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_held = 1'b0;
			caps_active = 1'b0;
			predicted_results.delete();
			pending_count = 0;
		end else begin
			if (scan.valid && scan.ready)
				predicted_results.push_back(predict_key(scan.scan_code));
			if (result.valid && result.ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", result.ascii_char, 0);
				end else begin
					oldest = predicted_results.pop_front();
					if (result.char_valid !== oldest.char_valid)
						report_mismatch("char_valid", result.char_valid, oldest.char_valid);
					if (result.ascii_char !== oldest.ascii_char)
						report_mismatch("ascii_char", result.ascii_char, oldest.ascii_char);
					if (result.caps_on !== oldest.caps_on)
						report_mismatch("caps_on", result.caps_on, oldest.caps_on);
					if (result.caps_toggled !== oldest.caps_toggled)
						report_mismatch("caps_toggled", result.caps_toggled,
							oldest.caps_toggled);
					char_count += oldest.char_valid;
					toggle_count += oldest.caps_toggled;
				end
			end
			pending_count = predicted_results.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the scan code translator. The checker beside the block
// watches both channels, predicts every result and counts mismatches; this module
// only drives scan codes, throttles the result side and decides pass or fail.
module testbench;
	import ksa_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;
	logic steady;
	int   cycle_count = 0;
	int   directed_sent = 0;
	int   random_sent = 0;
	int   mismatches;
	int   pending;
	int   chars_seen;
	int   toggles_seen;

	ksa_in_if  scan_ch ();
	ksa_out_if res_ch ();

	keyboard_scancode_to_ascii uut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.result (res_ch)
	);

	scancode_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan         (scan_ch),
		.result       (res_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.chars_seen   (chars_seen),
		.toggles_seen (toggles_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// The run is cut off here if the block ever stops moving items.
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// The result side stalls at random with a chance of 14 in a hundred, except during the
	// steady stretch, where it is always ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= steady || ($urandom_range(99) >= 14);
		end
	end

	// Offers one scan code and returns at the rising edge that accepts it. The
	// sender idles at random before the item unless the steady stretch is on.
	task automatic send_code(input logic [7:0] code);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 14) begin
			scan_ch.valid <= 1'b0;
			@(negedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.scan_code <= code;
		@(posedge clk);
		while (!scan_ch.ready) @(posedge clk);
	endtask

	// Holds the sender off until the checker has seen every predicted result.
	task automatic drain_results();
		@(negedge clk);
		scan_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Directed list: the extremes of the byte, both shift keys, caps lock on and
	// off, letters and symbols under every mix of shift and caps, the caps lock
	// release, other releases, and keys with no character such as Escape, Tab,
	// Ctrl and Alt.
	logic [7:0] directed_codes[] = '{
		8'h00, 8'hFF, 8'h7F, 8'h40, 8'h3F, 8'h80,
		8'h1E, 8'h02,
		LSHIFT_MAKE, 8'h1E, 8'h02, 8'h37, LSHIFT_BREAK,
		CAPS_MAKE, 8'h1E, 8'h02, 8'h29,
		RSHIFT_MAKE, 8'h1E, 8'h0C, RSHIFT_BREAK,
		CAPS_MAKE | 8'h80, CAPS_MAKE,
		8'h01, 8'h0F, 8'h1D, 8'h38, 8'h9E, 8'h0E, 8'h1C, 8'h39
	};

	logic [7:0] burst[$];
	logic [7:0] key;
	logic [7:0] shift_key;
	int         pick;

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		scan_ch.valid = 1'b0;
		scan_ch.scan_code = 8'h00;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_codes[i]) begin
			send_code(directed_codes[i]);
			directed_sent++;
		end
		drain_results();

		// Random part: mostly key strokes as a keyboard would send them, make
		// code then often its break code, shifted runs framed by a shift make and
		// break, caps lock taps, and some raw bytes over the full range as noise.
		while (random_sent < RANDOM_ITEMS) begin
			burst.delete();
			pick = $urandom_range(99);
			if (pick < 50) begin
				key = 8'($urandom_range(63));
				burst.push_back(key);
				if ($urandom_range(1))
					burst.push_back(key | 8'h80);
			end else if (pick < 64) begin
				shift_key = $urandom_range(1) ? LSHIFT_MAKE : RSHIFT_MAKE;
				burst.push_back(shift_key);
				repeat ($urandom_range(4, 1)) burst.push_back(8'($urandom_range(63)));
				burst.push_back(shift_key | 8'h80);
			end else if (pick < 71) begin
				burst.push_back(CAPS_MAKE);
				burst.push_back(CAPS_MAKE | 8'h80);
			end else begin
				burst.push_back(8'($urandom_range(255)));
			end
			foreach (burst[i]) begin
				send_code(burst[i]);
				random_sent++;
				steady = (random_sent >= 250 && random_sent < 400);
			end
			// Once, at the burst that passes 500 items, the sender waits for every result to land.
			if (random_sent >= 500 && random_sent < 500 + burst.size())
				drain_results();
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d scan codes (%0d directed, %0d random) with idle gaps on both sides,",
			directed_sent + random_sent, directed_sent, random_sent);
		$display("a steady stretch and a drain pause; %0d characters and %0d caps toggles came out.",
			chars_seen, toggles_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/ksa_pkg.sv
sv/ksa_in_if.sv
sv/ksa_out_if.sv
sv/ksa_lookup.sv
sv/ksa_decode.sv
sv/keyboard_scancode_to_ascii.sv
sv/ksa_checker.sv
test/scancode_checker.sv
test/testbench.sv
